// ----- hw/rtl/jst_pkg.sv -----
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants for the job slot table.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int SLOT_W    = 8;
    localparam int SLOTS     = 1 << SLOT_W;
    localparam int GEN_W     = 48;
    localparam int CNT_W     = 15;
    localparam int PEND_W    = 16;
    localparam int WIDX_W    = 14;
    localparam int OCC_W     = 9;
    localparam int WRK_W     = 5;
    localparam int QDEPTH_SH = 10;   // queue depth 1024
    localparam logic [WRK_W-1:0] WORKER_LIMIT = 5'd16;
    localparam logic [WRK_W-1:0] WORKER_DFLT  = 5'd4;

    typedef enum logic [1:0] {
        KIND_SUBMIT   = 2'd0,
        KIND_CLAIM    = 2'd1,
        KIND_COMPLETE = 2'd2,
        KIND_QUERY    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_STALE  = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXEC,
        S_PROBE,
        S_PARENT,
        S_WALK,
        S_OUT
    } state_t;

    // slot record kept in the table memory
    typedef struct packed {
        logic [GEN_W-1:0]  gen;
        logic [CNT_W-1:0]  items;
        logic [CNT_W-1:0]  claimed;
        logic [PEND_W-1:0] pending;
        logic [SLOT_W-1:0] pslot;
        logic [GEN_W-1:0]  pgen;
    } slot_rec_t;

endpackage

// ----- hw/rtl/job_slot_table_with_generations.sv -----
// ----------------------------------------------------------------------------
// job_slot_table_with_generations
// Slot pool handing out generation-tagged job handles.
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata: item_count,slot,gen; tuser: kind
// m_axis    out  m_axis_tvalid/tready      tdata: slot,gen,widx,fin,live; tuser: status
// cfg       in   cfg_valid/cfg_ready       worker_count
//
// One item at a time through a slot memory with a write port and a registered read port.
// Claim, query, rejected submit, stale complete: read, execute, output. Placed submit:
// probe from a rotating start past occupied slots, write the record, bump a live parent.
// Full table: every slot probed, then rejected. Live complete: drop pending; at zero, free
// the slot and repeat on the parent while it is live. Reset: a sweep clears the slot memory;
// no beat taken then. Results wait in an output register; the next item runs meanwhile.
// ----------------------------------------------------------------------------
module job_slot_table_with_generations
    import jst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [14:0] item_count, [22:15] handle_slot, [70:23] handle_generation
    input  logic [71:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] out_slot, [55:8] out_generation, [69:56] work_index,
    // [70] finished, [79:71] live_jobs
    output logic [79:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]  m_axis_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    slot_rec_t mem [SLOTS];
    slot_rec_t rd_reg;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg;
    logic              clr_busy_reg;

    // item latch
    kind_t             kind_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [SLOT_W-1:0] hslot_reg;
    logic [GEN_W-1:0]  hgen_reg;

    logic [GEN_W-1:0]  ngen_reg;
    logic [SLOT_W-1:0] pstart_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [WRK_W-1:0]  wrk_reg;

    logic [SLOT_W-1:0] addr_reg;      // current memory address
    logic [SLOT_W:0]   probe_n_reg;   // probes done
    logic [SLOT_W-1:0] found_reg;
    logic [GEN_W-1:0]  gen_reg;       // generation given to new job

    status_t           st_reg;
    logic [WIDX_W-1:0] widx_reg;
    logic              fin_reg;
    logic [SLOT_W-1:0] oslot_reg;
    logic [GEN_W-1:0]  ogen_reg;
    logic              mval_reg;

    // output beat register
    logic [79:0]       m_data_reg;
    status_t           m_user_reg;
    logic              out_load;

    // memory port controls
    logic              we;
    logic [SLOT_W-1:0] waddr, raddr;
    slot_rec_t         wdata;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    logic [WRK_W-1:0] eff_w;
    logic [CNT_W:0]   cap;
    logic             live_h;
    logic [GEN_W-1:0] gen_cur, gen_inc;
    logic [PEND_W-1:0] pend_dec;

    always_comb
    begin
        eff_w = wrk_reg;
        if (eff_w == '0)
            eff_w = WORKER_DFLT;
        if (eff_w > WORKER_LIMIT)
            eff_w = WORKER_LIMIT;
        cap = {{(CNT_W+1-WRK_W){1'b0}}, eff_w} << QDEPTH_SH;
        live_h = (hgen_reg != '0) && (rd_reg.gen == hgen_reg);
        gen_cur = (ngen_reg == '0) ? {{(GEN_W-1){1'b0}}, 1'b1} : ngen_reg;
        gen_inc = gen_cur + 1'b1;
        if (gen_inc == '0)
            gen_inc = {{(GEN_W-1){1'b0}}, 1'b1};
        pend_dec = (rd_reg.pending != '0) ? rd_reg.pending - 1'b1 : rd_reg.pending;
    end

    assign s_axis_tready = (state_reg == S_IDLE) && !clr_busy_reg;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = mval_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    // result moves to the output register once the previous beat is gone
    assign out_load = (state_reg == S_OUT) && (!mval_reg || m_axis_tready);

    logic s_acc;
    assign s_acc = s_axis_tvalid && s_axis_tready;

    // next state and memory controls
    always_comb
    begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = addr_reg;
        wdata = rd_reg;
        raddr = addr_reg;
        if (clr_busy_reg)
        begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_acc)
                    state_next = S_RD;
            end
            S_RD:   state_next = S_EXEC;
            S_EXEC:
            begin
                state_next = S_OUT;
                unique case (kind_reg)
                    KIND_SUBMIT:
                    begin
                        if (!(cnt_reg == '0 || {1'b0, cnt_reg} > cap))
                        begin
                            raddr      = pstart_reg;   // first probe
                            state_next = S_PROBE;
                        end
                    end
                    KIND_CLAIM:
                    begin
                        if (live_h && rd_reg.claimed < rd_reg.items)
                        begin
                            we    = 1'b1;
                            wdata.claimed = rd_reg.claimed + 1'b1;
                        end
                    end
                    KIND_COMPLETE:
                    begin
                        if (live_h)
                            state_next = S_WALK;
                    end
                    KIND_QUERY: ;
                    default: ;
                endcase
            end
            S_PROBE:
            begin
                // rd_reg holds slot addr_reg from previous cycle
                raddr = addr_reg + 1'b1;
                if (rd_reg.gen == '0)
                begin
                    raddr = hslot_reg;
                    state_next = S_PARENT;
                end
                else if (probe_n_reg == SLOTS[SLOT_W:0] - 1'b1)
                    state_next = S_OUT;
            end
            S_PARENT:
            begin
                // rd_reg holds parent slot record
                raddr = hslot_reg;
                we    = 1'b1;
                waddr = found_reg;
                wdata.gen     = gen_reg;
                wdata.items   = cnt_reg;
                wdata.claimed = '0;
                wdata.pending = {1'b0, cnt_reg};
                wdata.pslot   = '0;
                wdata.pgen    = '0;
                if (live_h)
                begin
                    wdata.pslot = hslot_reg;
                    wdata.pgen  = hgen_reg;
                    state_next  = S_RD;   // reuse: write parent bump next
                end
                else
                    state_next = S_OUT;
            end
            S_WALK:
            begin
                we    = 1'b1;
                wdata.pending = pend_dec;
                state_next = S_OUT;
                if (pend_dec == '0)
                begin
                    wdata.gen = '0;
                    if (rd_reg.pgen != '0)
                    begin
                        raddr = rd_reg.pslot;
                        state_next = S_RD;
                    end
                end
            end
            S_OUT:
            begin
                if (!mval_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        // parent bump after submit: S_RD with kind submit and found set
        if (state_reg == S_RD && kind_reg == KIND_SUBMIT && probe_n_reg[SLOT_W])
        begin
            we    = 1'b1;
            wdata.pending = (rd_reg.pending != '1) ? rd_reg.pending + 1'b1 : rd_reg.pending;
            state_next = S_OUT;
        end
        // walk step: S_RD with complete after first; check parent liveness
        if (state_reg == S_RD && kind_reg == KIND_COMPLETE && probe_n_reg[SLOT_W])
        begin
            state_next = (rd_reg.gen == hgen_reg) ? S_WALK : S_OUT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clr_reg      <= '0;
            clr_busy_reg <= 1'b1;
            ngen_reg     <= {{(GEN_W-1){1'b0}}, 1'b1};
            pstart_reg   <= '0;
            occ_reg      <= '0;
            wrk_reg      <= WORKER_DFLT;
            mval_reg     <= 1'b0;
            probe_n_reg  <= '0;
            m_data_reg   <= '0;
            m_user_reg   <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            if (clr_busy_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(SLOTS - 1))
                    clr_busy_reg <= 1'b0;
            end
            if (cfg_valid)
                wrk_reg <= cfg_data;
            if (out_load)
            begin
                mval_reg   <= 1'b1;
                m_data_reg <= {occ_reg, fin_reg, widx_reg, ogen_reg, oslot_reg};
                m_user_reg <= st_reg;
            end
            else if (mval_reg && m_axis_tready)
                mval_reg <= 1'b0;
            if (s_acc)
            begin
                kind_reg    <= kind_t'(s_axis_tuser);
                cnt_reg     <= s_axis_tdata[14:0];
                hslot_reg   <= s_axis_tdata[22:15];
                hgen_reg    <= s_axis_tdata[70:23];
                addr_reg    <= s_axis_tdata[22:15];
                probe_n_reg <= '0;
                st_reg      <= ST_OK;
                widx_reg    <= '0;
                fin_reg     <= 1'b0;
                oslot_reg   <= '0;
                ogen_reg    <= '0;
            end
            unique case (state_reg)
                S_EXEC:
                begin
                    unique case (kind_reg)
                        KIND_SUBMIT:
                        begin
                            if (cnt_reg == '0 || {1'b0, cnt_reg} > cap)
                                st_reg <= ST_REJECT;
                            else
                            begin
                                addr_reg   <= pstart_reg;
                                pstart_reg <= pstart_reg + 1'b1;
                            end
                        end
                        KIND_CLAIM:
                        begin
                            if (!live_h)
                                st_reg <= ST_STALE;
                            else if (rd_reg.claimed < rd_reg.items)
                                widx_reg <= rd_reg.claimed[WIDX_W-1:0];
                            else
                                st_reg <= ST_EMPTY;
                        end
                        KIND_COMPLETE:
                        begin
                            if (!live_h)
                                st_reg <= ST_STALE;
                        end
                        KIND_QUERY:
                            fin_reg <= !live_h || (rd_reg.pending == '0);
                        default: ;
                    endcase
                end
                S_PROBE:
                begin
                    if (rd_reg.gen == '0)
                    begin
                        found_reg <= addr_reg;
                        gen_reg   <= gen_cur;
                        ngen_reg  <= gen_inc;
                        occ_reg   <= occ_reg + 1'b1;
                        oslot_reg <= addr_reg;
                        ogen_reg  <= gen_cur;
                        addr_reg  <= hslot_reg;
                    end
                    else
                    begin
                        addr_reg    <= addr_reg + 1'b1;
                        probe_n_reg <= probe_n_reg + 1'b1;
                        if (probe_n_reg == SLOTS[SLOT_W:0] - 1'b1)
                            st_reg <= ST_REJECT;
                    end
                end
                S_PARENT:
                    probe_n_reg <= {1'b1, {SLOT_W{1'b0}}};
                S_WALK:
                begin
                    if (pend_dec == '0)
                    begin
                        if (occ_reg != '0)
                            occ_reg <= occ_reg - 1'b1;
                        addr_reg    <= rd_reg.pslot;
                        hgen_reg    <= rd_reg.pgen;
                        probe_n_reg <= {1'b1, {SLOT_W{1'b0}}};
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- tb/sv/tb_job_slot_table_with_generations.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_job_slot_table_with_generations
// Self-checking bench for the generation-tagged job slot table.
// Directed tests cover count limits, claims, parent chains, worker settings
// and a full table. A random phase of mostly well-formed traffic follows.
// A local slot-table model predicts every result beat, and the checker
// compares each beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_job_slot_table_with_generations;
    import jst_pkg::*;

    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        status_t           st;
        logic [SLOT_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
        logic [WIDX_W-1:0] widx;
        logic              fin;
        logic [OCC_W-1:0]  live;
    } job_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;

    // local copy of the slot table
    logic [GEN_W-1:0]  tbl_gen     [SLOTS];
    logic [CNT_W-1:0]  tbl_items   [SLOTS];
    logic [CNT_W-1:0]  tbl_claimed [SLOTS];
    logic [PEND_W-1:0] tbl_pending [SLOTS];
    logic [SLOT_W-1:0] tbl_pslot   [SLOTS];
    logic [GEN_W-1:0]  tbl_pgen    [SLOTS];
    logic [GEN_W-1:0]  gen_next;
    logic [SLOT_W-1:0] probe_pos;
    int unsigned       live_count;
    logic [4:0]        workers;

    job_result_t expected_q[$];
    int          mismatches;
    int          idle_cycles;
    bit          calm;   // no idling on either side while set

    job_slot_table_with_generations dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit is_live(logic [SLOT_W-1:0] s, logic [GEN_W-1:0] g);
        return g != '0 && tbl_gen[s] == g;
    endfunction

    // submit limit is queue depth times the effective worker count
    function automatic int unsigned submit_cap();
        int unsigned w;
        w = 32'(workers);
        if (w == 0) w = 32'(WORKER_DFLT);
        if (w > 32'(WORKER_LIMIT)) w = 32'(WORKER_LIMIT);
        return w << QDEPTH_SH;
    endfunction

    // one finished item: drop pending, free at zero and walk to the parent
    function automatic void retire_item(logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] ps;
        logic [GEN_W-1:0]  pg;
        cur = s;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_pending[cur] > 0) tbl_pending[cur]--;
            if (tbl_pending[cur] != 0) return;
            ps = tbl_pslot[cur];
            pg = tbl_pgen[cur];
            tbl_gen[cur] = '0;
            if (live_count > 0) live_count--;
            if (!is_live(ps, pg)) return;
            cur = ps;
        end
    endfunction

    function automatic job_result_t apply_job_op(kind_t k, logic [CNT_W-1:0] cnt,
                                                 logic [SLOT_W-1:0] hs,
                                                 logic [GEN_W-1:0] hg);
        job_result_t r;
        int          found;
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;
        r = '0;
        r.st = ST_OK;
        case (k)
            KIND_SUBMIT:
            begin
                if (cnt == 0 || cnt > submit_cap())
                    r.st = ST_REJECT;
                else
                begin
                    found = -1;
                    for (int a = 0; a < SLOTS; a++)
                    begin
                        s = probe_pos + SLOT_W'(a);
                        if (found < 0 && tbl_gen[s] == '0) found = int'(s);
                    end
                    probe_pos++;
                    if (found < 0)
                        r.st = ST_REJECT;
                    else
                    begin
                        g = (gen_next == '0) ? 48'd1 : gen_next;
                        gen_next = g + 1'b1;
                        if (gen_next == '0) gen_next = 48'd1;
                        if (is_live(hs, hg))
                        begin
                            if (tbl_pending[hs] != '1) tbl_pending[hs]++;
                            tbl_pslot[found] = hs;
                            tbl_pgen[found]  = hg;
                        end
                        else
                        begin
                            tbl_pslot[found] = '0;
                            tbl_pgen[found]  = '0;
                        end
                        tbl_gen[found]     = g;
                        tbl_items[found]   = cnt;
                        tbl_claimed[found] = '0;
                        tbl_pending[found] = {1'b0, cnt};
                        live_count++;
                        r.slot = SLOT_W'(found);
                        r.gen  = g;
                    end
                end
            end
            KIND_CLAIM:
            begin
                if (!is_live(hs, hg))
                    r.st = ST_STALE;
                else if (tbl_claimed[hs] < tbl_items[hs])
                begin
                    r.widx = tbl_claimed[hs][WIDX_W-1:0];
                    tbl_claimed[hs]++;
                end
                else
                    r.st = ST_EMPTY;
            end
            KIND_COMPLETE:
            begin
                if (!is_live(hs, hg)) r.st = ST_STALE;
                else retire_item(hs);
            end
            default:
                r.fin = !is_live(hs, hg) || tbl_pending[hs] == 0;
        endcase
        r.live = OCC_W'(live_count);
        return r;
    endfunction

    // shared sender: leaves tvalid high after the beat; the next call owns it
    task automatic send_job_op(kind_t k, logic [CNT_W-1:0] cnt,
                               logic [SLOT_W-1:0] hs, logic [GEN_W-1:0] hg);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(99) < 25)
        begin
            gap = $urandom_range(4, 1);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= {1'b0, hg, hs, cnt};
        s_axis_tuser  <= k;
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        expected_q.push_back(apply_job_op(k, cnt, hs, hg));
    endtask

    // stop sending and let every expected beat come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_workers(logic [4:0] w);
        drain_results();
        @(negedge clk);
        cfg_data  <= w;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        workers = w;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random live handle; returns 0 if the table is empty
    function automatic bit pick_live(output logic [SLOT_W-1:0] s,
                                     output logic [GEN_W-1:0] g);
        logic [SLOT_W-1:0] base;
        base = SLOT_W'($urandom);
        for (int i = 0; i < SLOTS; i++)
        begin
            s = base + SLOT_W'(i);
            g = tbl_gen[s];
            if (g != '0) return 1'b1;
        end
        s = '0;
        g = '0;
        return 1'b0;
    endfunction

    function automatic logic [GEN_W-1:0] rand_gen();
        return GEN_W'({$urandom, $urandom});
    endfunction

    // complete every job that needs only a few more items
    task automatic retire_small_jobs();
        bit any;
        do
        begin
            any = 1'b0;
            for (int s = 0; s < SLOTS; s++)
                if (tbl_gen[s] != '0 && tbl_pending[s] <= 8)
                begin
                    any = 1'b1;
                    send_job_op(KIND_COMPLETE, '0, SLOT_W'(s), tbl_gen[s]);
                end
        end
        while (any);
    endtask

    // ---------------- tests ----------------

    task automatic test_count_limits();
        send_job_op(KIND_QUERY, '0, '0, '0);                 // null handle
        send_job_op(KIND_SUBMIT, '0, '0, '0);                // zero count
        send_job_op(KIND_SUBMIT, 15'd4096, '0, '0);          // default cap
        send_job_op(KIND_SUBMIT, 15'd4097, '0, '0);
        write_workers(5'd1);
        send_job_op(KIND_SUBMIT, 15'd1024, '0, '0);
        send_job_op(KIND_SUBMIT, 15'd1025, '0, '0);
        write_workers(5'd16);
        send_job_op(KIND_SUBMIT, 15'd16384, 8'hFF, '1);      // dead parent, all ones
        send_job_op(KIND_SUBMIT, 15'h7FFF, '0, '0);
        write_workers(5'd31);                                // clamps to limit
        send_job_op(KIND_SUBMIT, 15'd16385, '0, '0);
        write_workers(5'd0);                                 // acts as default
        send_job_op(KIND_SUBMIT, 15'd4097, '0, '0);
    endtask

    task automatic test_claims();
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;
        drain_results();
        send_job_op(KIND_SUBMIT, 15'd2, '0, '0);
        drain_results();
        s = expected_q.size() == 0 ? probe_pos - 1'b1 : '0;
        g = tbl_gen[s];
        repeat (3) send_job_op(KIND_CLAIM, '0, s, g);        // last one exhausted
        send_job_op(KIND_CLAIM, '0, s, g ^ 48'h1);           // stale
        send_job_op(KIND_COMPLETE, '0, s, g + 1'b1);         // stale
        send_job_op(KIND_QUERY, '0, s, g);
        send_job_op(KIND_COMPLETE, '0, s, g);
        send_job_op(KIND_COMPLETE, '0, s, g);                // frees it
        send_job_op(KIND_QUERY, '0, s, g);                   // stale reads finished
        send_job_op(KIND_CLAIM, '0, s, g);
    endtask

    task automatic test_parent_chain();
        logic [SLOT_W-1:0] hs[3];
        logic [GEN_W-1:0]  hg[3];
        // grandparent <- parent <- child, each with one item
        for (int i = 0; i < 3; i++)
        begin
            drain_results();
            send_job_op(KIND_SUBMIT, 15'd1, i ? hs[i-1] : '0, i ? hg[i-1] : '0);
            drain_results();
            hs[i] = probe_pos - 1'b1;
            while (tbl_gen[hs[i]] == '0 || (i > 0 && hs[i] == hs[i-1])) hs[i]++;
            hg[i] = gen_next - 1'b1;
            if (hg[i] == '0) hg[i] = '1;
            for (int s = 0; s < SLOTS; s++)
                if (tbl_gen[s] == hg[i]) hs[i] = SLOT_W'(s);
        end
        send_job_op(KIND_COMPLETE, '0, hs[0], hg[0]);        // own item only
        send_job_op(KIND_QUERY, '0, hs[0], hg[0]);
        send_job_op(KIND_COMPLETE, '0, hs[1], hg[1]);
        send_job_op(KIND_COMPLETE, '0, hs[2], hg[2]);        // walks to the top
        send_job_op(KIND_QUERY, '0, hs[0], hg[0]);
    endtask

    task automatic test_table_full();
        drain_results();
        retire_small_jobs();
        while (live_count < SLOTS)
            send_job_op(KIND_SUBMIT, 15'd1, '0, '0);
        send_job_op(KIND_SUBMIT, 15'd1, '0, '0);             // no free slot
        send_job_op(KIND_SUBMIT, 15'd3, '0, '0);
        retire_small_jobs();
    endtask

    task automatic test_random_traffic(int n);
        logic [SLOT_W-1:0] s;
        logic [GEN_W-1:0]  g;
        logic [CNT_W-1:0]  c;
        int r;
        for (int i = 0; i < n; i++)
        begin
            if (i % 100 == 99)
                write_workers(5'($urandom_range(31)));
            if (i == 150)
                drain_results();                             // sender holds off
            calm = (i >= 60 && i < 140);
            r = $urandom_range(99);
            if (r < 30 && live_count < 200)
            begin
                c = ($urandom_range(9) != 0) ? CNT_W'($urandom_range(4, 1))
                                             : CNT_W'($urandom);
                if ($urandom_range(9) < 6 && pick_live(s, g))
                    send_job_op(KIND_SUBMIT, c, s, g);
                else
                    send_job_op(KIND_SUBMIT, c, SLOT_W'($urandom),
                                ($urandom_range(1) != 0) ? '0 : rand_gen());
            end
            else if (r < 92 && pick_live(s, g))
            begin
                if (r < 45) send_job_op(KIND_CLAIM, CNT_W'($urandom), s, g);
                else if (r < 80) send_job_op(KIND_COMPLETE, CNT_W'($urandom), s, g);
                else send_job_op(KIND_QUERY, CNT_W'($urandom), s, g);
            end
            else
                send_job_op(kind_t'(2'($urandom_range(3))), CNT_W'($urandom),
                            SLOT_W'($urandom),
                            ($urandom_range(1) != 0) ? rand_gen() : {40'd0, 8'($urandom)});
        end
        calm = 1'b0;
    endtask

    // ---------------- result checking ----------------

    always @(posedge clk)
    begin
        job_result_t got;
        job_result_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.st   = status_t'(m_axis_tuser);
            got.slot = m_axis_tdata[7:0];
            got.gen  = m_axis_tdata[55:8];
            got.widx = m_axis_tdata[69:56];
            got.fin  = m_axis_tdata[70];
            got.live = m_axis_tdata[79:71];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.st !== want.st || got.slot !== want.slot || got.gen !== want.gen ||
                    got.widx !== want.widx || got.fin !== want.fin ||
                    got.live !== want.live)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 25);

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            tbl_gen[s] = '0; tbl_items[s] = '0; tbl_claimed[s] = '0;
            tbl_pending[s] = '0; tbl_pslot[s] = '0; tbl_pgen[s] = '0;
        end
        gen_next   = 48'd1;
        probe_pos  = '0;
        live_count = 0;
        workers    = WORKER_DFLT;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_count_limits();
        test_claims();
        test_parent_chain();
        test_table_full();
        write_workers(5'd2);
        test_random_traffic(210);

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
